/* sv/csf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csf_pkg
// Types and constants shared by the command stream finder modules.
// ----------------------------------------------------------------------------
package csf_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned CLASS_W = 3;

  localparam logic [32:0] MAX_BUF_WORDS = 33'd65536;

  localparam logic [CLASS_W-1:0] CLASS_MI  = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_GFX = 3'd3;

  localparam logic [WORD_W-1:0] OP_NOOP           = 32'h0000_0000;
  localparam logic [WORD_W-1:0] OP_BB_END         = 32'h0500_0000;
  localparam logic [WORD_W-1:0] OP_FLUSH_DW       = 32'h1300_0000;
  localparam logic [WORD_W-1:0] OP_STORE_DATA_IMM = 32'h1000_0000;
  localparam logic [WORD_W-1:0] OP_MFX_WAIT       = 32'h6800_0000;

  localparam logic [WORD_W-1:0] MI_OP_MASK  = 32'hFF80_0000;
  localparam logic [WORD_W-1:0] GFX_OP_MASK = 32'hFFFF_0000;

  typedef struct packed {
    logic [WORD_W-1:0] opcode;
    logic [LEN_W-1:0]  len;
  } dec_t;

endpackage
`default_nettype wire

/* sv/csf_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csf_decoder
// Decodes one command header into its opcode and length in dwords.
// ----------------------------------------------------------------------------
module csf_decoder
  import csf_pkg::*;
(
  input  wire logic [WORD_W-1:0] hdr,
  output dec_t                   dec
);

  logic [WORD_W-1:0] mi_op;
  logic [WORD_W-1:0] gfx_op;

  assign mi_op  = hdr & MI_OP_MASK;
  assign gfx_op = hdr & GFX_OP_MASK;

  always_comb begin
    dec.opcode = hdr;
    dec.len    = LEN_W'(1);
    unique case (hdr[WORD_W-1 -: CLASS_W])
      CLASS_MI: begin
        dec.opcode = mi_op;
        if (mi_op == OP_NOOP || mi_op == OP_BB_END) begin
          dec.len = LEN_W'(1);
        end else if (mi_op == OP_FLUSH_DW) begin
          dec.len = LEN_W'(hdr[4:0]) + LEN_W'(2);
        end else if (mi_op == OP_STORE_DATA_IMM) begin
          dec.len = LEN_W'(hdr[9:0]) + LEN_W'(2);
        end else begin
          dec.len = LEN_W'(hdr[7:0]) + LEN_W'(2);
        end
      end
      CLASS_GFX: begin
        dec.opcode = gfx_op;
        if (gfx_op == OP_MFX_WAIT) begin
          dec.len = LEN_W'(1);
        end else begin
          dec.len = LEN_W'(hdr[11:0]) + LEN_W'(2);
        end
      end
      default: begin
        dec.opcode = hdr;
        dec.len    = LEN_W'(1);
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/command_stream_finder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// command_stream_finder
// Walks a command buffer one dword per transaction and finds a target opcode.
// ----------------------------------------------------------------------------
// Each input transaction yields exactly one result transaction in the cycle
// after, and a new dword is taken every cycle while the result side keeps up.
// The header decode and skip-count update sit between the input handshake and
// a single result register, so the result register is the only output stage.
// The target opcode may be written only while no transaction is in flight.
module command_stream_finder
  import csf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [WORD_W-1:0] cfg_target_opcode,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WORD_W-1:0] in_word,
  input  wire logic              in_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_is_header,
  output logic [WORD_W-1:0]      out_cmd_opcode,
  output logic [LEN_W-1:0]       out_cmd_len,
  output logic                   out_found,
  output logic                   out_ended,
  output logic [POS_W-1:0]       out_position
);

  logic [WORD_W-1:0] target_r;
  logic [LEN_W-1:0]  skip_r, skip_nxt;
  logic [POS_W-1:0]  index_r, index_nxt;
  logic              done_r, done_nxt;
  logic              valid_r;
  logic              is_hdr_r, is_hdr_nxt;
  logic [WORD_W-1:0] op_r, op_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              found_r, found_nxt;
  logic              ended_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W:0]    index_inc;
  logic              accept;
  dec_t              dec;

  csf_decoder u_dec (
    .hdr (in_word),
    .dec (dec)
  );

  assign in_ready  = !valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign index_inc = {1'b0, index_r} + (POS_W+1)'(1);

  always_comb begin
    skip_nxt   = skip_r;
    done_nxt   = done_r;
    is_hdr_nxt = 1'b0;
    op_nxt     = '0;
    len_nxt    = '0;
    found_nxt  = 1'b0;
    if (!done_r) begin
      if (skip_r != '0) begin
        skip_nxt = skip_r - LEN_W'(1);
      end else begin
        is_hdr_nxt = 1'b1;
        op_nxt     = dec.opcode;
        len_nxt    = dec.len;
        found_nxt  = (dec.opcode == target_r);
        if (found_nxt || dec.opcode == OP_BB_END) begin
          done_nxt = 1'b1;
        end else begin
          skip_nxt = dec.len - LEN_W'(1);
        end
      end
    end
    if (index_inc[POS_W] || 33'(index_inc) >= MAX_BUF_WORDS) begin
      index_nxt = '0;
    end else begin
      index_nxt = index_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      skip_r   <= '0;
      index_r  <= '0;
      done_r   <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        target_r <= cfg_target_opcode;
      end
      if (accept) begin
        valid_r <= 1'b1;
        if (in_last) begin
          skip_r  <= '0;
          index_r <= '0;
          done_r  <= 1'b0;
        end else begin
          skip_r  <= skip_nxt;
          index_r <= index_nxt;
          done_r  <= done_nxt;
        end
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_hdr_r <= is_hdr_nxt;
      op_r     <= op_nxt;
      len_r    <= len_nxt;
      found_r  <= found_nxt;
      ended_r  <= done_nxt;
      pos_r    <= index_r;
    end
  end

  assign out_valid      = valid_r;
  assign out_is_header  = is_hdr_r;
  assign out_cmd_opcode = op_r;
  assign out_cmd_len    = len_r;
  assign out_found      = found_r;
  assign out_ended      = ended_r;
  assign out_position   = pos_r;

endmodule
`default_nettype wire

/* sv/csf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csf_checker
// Port-level checks on the command stream finder, bound to its top level.
// ----------------------------------------------------------------------------
module csf_checker
  import csf_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_is_header,
  input wire logic [WORD_W-1:0] out_cmd_opcode,
  input wire logic [LEN_W-1:0]  out_cmd_len,
  input wire logic              out_found,
  input wire logic              out_ended,
  input wire logic [POS_W-1:0]  out_position
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cmd_opcode)
      && $stable(out_position) && $stable(out_cmd_len))
    else $error("result transaction changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_header |-> out_cmd_opcode == '0 && out_cmd_len == '0
      && !out_found)
    else $error("non-header result carries decode fields");

  a_found_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_is_header && out_ended)
    else $error("match did not end the search");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_header |-> out_cmd_len != '0 && out_cmd_len <= LEN_W'(4097))
    else $error("header length out of range");

endmodule

bind command_stream_finder csf_checker u_csf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_is_header  (out_is_header),
  .out_cmd_opcode (out_cmd_opcode),
  .out_cmd_len    (out_cmd_len),
  .out_found      (out_found),
  .out_ended      (out_ended),
  .out_position   (out_position)
);
`default_nettype wire
